// ===== hdl/block_mean_pixelate_assert.svh =====
// Assertion macros for the block mean pixelate design.
// Needs a clock named clock and a reset named reset in the including module.
`ifndef BLOCK_MEAN_PIXELATE_ASSERT_SVH
`define BLOCK_MEAN_PIXELATE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define BMP_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled in reset
`define BMP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/bmp_pkg.sv =====
// Shared types and constants for the block mean pixelate design.
// No dependencies.
package bmp_pkg;

   localparam int CNT_W    = 12;  // pixel counters and tile indices
   localparam int TILE_W   = 7;   // tile edge and in-tile positions
   localparam int AREA_W   = 14;  // tile edge squared
   localparam int SUM_W    = 28;  // saturating channel sums
   localparam int CH_W     = 16;  // channel field width
   localparam int POS_W    = 11;  // origin field width
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 12;

   localparam int DEF_MAX_COLUMNS  = 2048;
   localparam int DEF_MAX_ROWS     = 2048;
   localparam int DEF_MAX_TILE     = 64;
   localparam int DEF_CHANNEL_BITS = 16;

   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_ROWS    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_COLUMNS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_TILE_SIZE     = 2'd2;

   typedef struct packed {
      logic            frame_start;
      logic [CH_W-1:0] red_in;
      logic [CH_W-1:0] green_in;
      logic [CH_W-1:0] blue_in;
   } req_type;

   typedef struct packed {
      logic [POS_W-1:0] origin_row;
      logic [POS_W-1:0] origin_col;
      logic [CH_W-1:0]  red_mean;
      logic [CH_W-1:0]  green_mean;
      logic [CH_W-1:0]  blue_mean;
      logic             frame_done;
   } rsp_type;

   typedef struct packed {
      logic clear_en;
      logic cfg_start;
      logic cfg_load;
      logic mean_start;
      logic rsp_load;
      logic pix_ready;
      logic csr_ready;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic cfg_done;
      logic mean_done;
      logic s1_valid;
      logic s1_last;
      logic rsp_free;
   } status_type;

endpackage

// ===== hdl/bmp_divider.sv =====
// Iterative restoring divider, one quotient bit per cycle.
// No package dependencies.
module bmp_divider #(
   parameter int DIVIDEND_W = 12,
   parameter int DIVISOR_W  = 7
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] quotient,
   output logic [DIVISOR_W-1:0]  remainder
);
   localparam int CNT_BITS = $clog2(DIVIDEND_W + 1);
   localparam logic [CNT_BITS-1:0] LAST_STEP = CNT_BITS'(DIVIDEND_W - 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  dsr_ff, dsr_in;
   logic [DIVISOR_W:0]    shifted;
   logic [DIVISOR_W:0]    diff;

   always_comb begin
      shifted = {rem_ff, quo_ff[DIVIDEND_W-1]};
      diff    = shifted - {1'b0, dsr_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         // take one bit: subtract when the partial remainder allows it
         if (!diff[DIVISOR_W]) begin
            rem_in = diff[DIVISOR_W-1:0];
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[DIVISOR_W-1:0];
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// ===== hdl/bmp_datapath.sv =====
// Datapath: configuration registers, raster counters, tile-column sum memory,
// dividers and the result register. Depends on bmp_pkg and bmp_divider.
module bmp_datapath #(
   parameter int MAX_COLUMNS  = bmp_pkg::DEF_MAX_COLUMNS,
   parameter int MAX_ROWS     = bmp_pkg::DEF_MAX_ROWS,
   parameter int MAX_TILE     = bmp_pkg::DEF_MAX_TILE,
   parameter int CHANNEL_BITS = bmp_pkg::DEF_CHANNEL_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  bmp_pkg::cmd_type                    cmd,
   output bmp_pkg::status_type                 st,
   input  logic                                req_valid,
   input  bmp_pkg::req_type                    req_data,
   input  logic                                csr_valid,
   input  logic [bmp_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [bmp_pkg::CSR_DATA_W-1:0]      csr_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output bmp_pkg::rsp_type                    rsp_data
);
   localparam int CNT_W  = bmp_pkg::CNT_W;
   localparam int TILE_W = bmp_pkg::TILE_W;
   localparam int AREA_W = bmp_pkg::AREA_W;
   localparam int SUM_W  = bmp_pkg::SUM_W;
   localparam int CH_W   = bmp_pkg::CH_W;
   localparam int POS_W  = bmp_pkg::POS_W;
   localparam int ADDR_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
   localparam logic [SUM_W-1:0] CH_MAX = SUM_W'((64'd1 << CHANNEL_BITS) - 64'd1);
   localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
   localparam logic [ADDR_W-1:0] CLEAR_LAST = ADDR_W'(MAX_COLUMNS - 1);

   logic accept, csr_we;

   // configuration
   logic [CNT_W-1:0]  rows_reg_ff, cols_reg_ff;
   logic [TILE_W-1:0] tile_reg_ff;
   logic [CNT_W-1:0]  rows_c, cols_c;
   logic [TILE_W-1:0] tile_c;

   // counters
   logic [CNT_W-1:0]  row_count_ff, col_count_ff, row_count_in, col_count_in;
   logic [TILE_W-1:0] row_in_tile_ff, col_in_tile_ff, row_in_tile_in, col_in_tile_in;
   logic [CNT_W-1:0]  tile_row_ff, tile_col_ff, tile_row_in, tile_col_in;
   logic [TILE_W-1:0] row_rem_ff, col_rem_ff, row_rem_in, col_rem_in;
   logic [CNT_W-1:0]  tile_rows_ff, tile_cols_ff;

   // current pixel view after frame start
   logic [CNT_W-1:0]  rc, cc, trc, tcc;
   logic [TILE_W-1:0] rit, cit, rrm, crm;
   logic [CNT_W:0]    cc1, rc1;
   logic [TILE_W:0]   cit1, rit1, crm1, rrm1;
   logic [CNT_W-1:0]  org_r, org_c;
   logic              pix_in_tile, pix_first, pix_last, pix_done;

   // stage one
   logic                 s1_valid_ff;
   logic                 s1_in_tile_ff, s1_first_ff, s1_last_ff, s1_done_ff;
   logic [ADDR_W-1:0]    s1_addr_ff;
   logic [POS_W-1:0]     s1_org_row_ff, s1_org_col_ff;
   logic [3*CH_W-1:0]    s1_pix_ff;

   // sum memory and forwarding
   logic [3*SUM_W-1:0] sum_mem [MAX_COLUMNS];
   logic [3*SUM_W-1:0] rd_data_ff, old_sums, new_sums, wr_data;
   logic [ADDR_W-1:0]  wr_addr, clear_addr_ff;
   logic               mem_we;
   logic               fw_valid_ff;
   logic [ADDR_W-1:0]  fw_addr_ff;
   logic [3*SUM_W-1:0] fw_data_ff;
   logic [SUM_W:0]     acc [3];

   // dividers
   logic [CNT_W-1:0]  cfg_q [4];
   logic [TILE_W-1:0] cfg_r [4];
   logic [CNT_W-1:0]  cfg_dividend [4];
   logic [3:0]        cfg_done;
   logic [SUM_W-1:0]  mean_q [3];
   logic [AREA_W-1:0] mean_r [3];
   logic [2:0]        mean_done;
   logic [AREA_W-1:0] area;
   logic [CH_W-1:0]   mean_sat [3];

   logic              rsp_valid_ff;
   bmp_pkg::rsp_type  rsp_data_ff;

   assign accept = req_valid && cmd.pix_ready;
   assign csr_we = csr_valid && cmd.csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_reg_ff <= CNT_W'(1);
         cols_reg_ff <= CNT_W'(1);
         tile_reg_ff <= TILE_W'(1);
      end else if (csr_we) begin
         unique case (csr_index)
            bmp_pkg::REG_IMAGE_ROWS:    rows_reg_ff <= csr_data;
            bmp_pkg::REG_IMAGE_COLUMNS: cols_reg_ff <= csr_data;
            bmp_pkg::REG_TILE_SIZE:     tile_reg_ff <= csr_data[TILE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      rows_c = (rows_reg_ff == '0) ? CNT_W'(1) :
               (rows_reg_ff > MAX_ROWS) ? CNT_W'(MAX_ROWS) : rows_reg_ff;
      cols_c = (cols_reg_ff == '0) ? CNT_W'(1) :
               (cols_reg_ff > MAX_COLUMNS) ? CNT_W'(MAX_COLUMNS) : cols_reg_ff;
      tile_c = (tile_reg_ff == '0) ? TILE_W'(1) :
               (tile_reg_ff > MAX_TILE) ? TILE_W'(MAX_TILE) : tile_reg_ff;
      area   = AREA_W'(tile_c * tile_c);
   end

   // pixel position bookkeeping
   always_comb begin
      rc  = req_data.frame_start ? '0 : row_count_ff;
      cc  = req_data.frame_start ? '0 : col_count_ff;
      rit = req_data.frame_start ? '0 : row_in_tile_ff;
      cit = req_data.frame_start ? '0 : col_in_tile_ff;
      trc = req_data.frame_start ? '0 : tile_row_ff;
      tcc = req_data.frame_start ? '0 : tile_col_ff;
      rrm = req_data.frame_start ? '0 : row_rem_ff;
      crm = req_data.frame_start ? '0 : col_rem_ff;

      pix_in_tile = (trc < tile_rows_ff) && (tcc < tile_cols_ff);
      pix_first   = (rit == '0) && (cit == '0);
      pix_last    = (rit == tile_c - 1'b1) && (cit == tile_c - 1'b1);
      pix_done    = (trc == tile_rows_ff - 1'b1) && (tcc == tile_cols_ff - 1'b1);
      org_r       = rc - CNT_W'(rit);
      org_c       = cc - CNT_W'(cit);

      cc1  = {1'b0, cc} + 1'b1;
      cit1 = {1'b0, cit} + 1'b1;
      crm1 = {1'b0, crm} + 1'b1;
      rc1  = {1'b0, rc} + 1'b1;
      rit1 = {1'b0, rit} + 1'b1;
      rrm1 = {1'b0, rrm} + 1'b1;

      row_count_in   = rc;
      row_in_tile_in = rit;
      tile_row_in    = trc;
      row_rem_in     = rrm;
      col_count_in   = cc1[CNT_W-1:0];
      col_in_tile_in = (cit1 >= {1'b0, tile_c}) ? '0 : cit1[TILE_W-1:0];
      if (crm1 == {1'b0, tile_c}) begin
         col_rem_in  = '0;
         tile_col_in = tcc + 1'b1;
      end else begin
         col_rem_in  = crm1[TILE_W-1:0];
         tile_col_in = tcc;
      end
      if (cc1 >= {1'b0, cols_c}) begin
         col_count_in   = '0;
         col_in_tile_in = '0;
         col_rem_in     = '0;
         tile_col_in    = '0;
         row_count_in   = rc1[CNT_W-1:0];
         row_in_tile_in = (rit1 >= {1'b0, tile_c}) ? '0 : rit1[TILE_W-1:0];
         if (rrm1 == {1'b0, tile_c}) begin
            row_rem_in  = '0;
            tile_row_in = trc + 1'b1;
         end else begin
            row_rem_in  = rrm1[TILE_W-1:0];
         end
         if (rc1 >= {1'b0, rows_c}) begin
            row_count_in   = '0;
            row_in_tile_in = '0;
            row_rem_in     = '0;
            tile_row_in    = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff   <= '0;
         col_count_ff   <= '0;
         row_in_tile_ff <= '0;
         col_in_tile_ff <= '0;
         tile_row_ff    <= '0;
         tile_col_ff    <= '0;
         row_rem_ff     <= '0;
         col_rem_ff     <= '0;
         tile_rows_ff   <= CNT_W'(1);
         tile_cols_ff   <= CNT_W'(1);
      end else if (cmd.cfg_load) begin
         // realign tile indices to the new bounds
         tile_row_ff  <= cfg_q[0];
         row_rem_ff   <= cfg_r[0];
         tile_col_ff  <= cfg_q[1];
         col_rem_ff   <= cfg_r[1];
         tile_rows_ff <= cfg_q[2];
         tile_cols_ff <= cfg_q[3];
      end else if (accept) begin
         row_count_ff   <= row_count_in;
         col_count_ff   <= col_count_in;
         row_in_tile_ff <= row_in_tile_in;
         col_in_tile_ff <= col_in_tile_in;
         tile_row_ff    <= tile_row_in;
         tile_col_ff    <= tile_col_in;
         row_rem_ff     <= row_rem_in;
         col_rem_ff     <= col_rem_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
      if (accept) begin
         s1_in_tile_ff <= pix_in_tile;
         s1_first_ff   <= pix_first;
         s1_last_ff    <= pix_last;
         s1_done_ff    <= pix_done;
         s1_addr_ff    <= ADDR_W'(tcc);
         s1_org_row_ff <= org_r[POS_W-1:0];
         s1_org_col_ff <= org_c[POS_W-1:0];
         s1_pix_ff     <= {req_data.red_in   & CH_MAX[CH_W-1:0],
                           req_data.green_in & CH_MAX[CH_W-1:0],
                           req_data.blue_in  & CH_MAX[CH_W-1:0]};
      end
   end

   // accumulate, with the last written row forwarded
   always_comb begin
      old_sums = (fw_valid_ff && fw_addr_ff == s1_addr_ff) ? fw_data_ff : rd_data_ff;
      for (int i = 0; i < 3; i++) begin
         acc[i] = {1'b0, old_sums[i*SUM_W +: SUM_W]} + (SUM_W+1)'(s1_pix_ff[i*CH_W +: CH_W]);
         if (s1_first_ff) begin
            new_sums[i*SUM_W +: SUM_W] = SUM_W'(s1_pix_ff[i*CH_W +: CH_W]);
         end else if (acc[i][SUM_W]) begin
            new_sums[i*SUM_W +: SUM_W] = SUM_MAX;
         end else begin
            new_sums[i*SUM_W +: SUM_W] = acc[i][SUM_W-1:0];
         end
      end
      mem_we  = cmd.clear_en || (s1_valid_ff && s1_in_tile_ff);
      wr_addr = cmd.clear_en ? clear_addr_ff : s1_addr_ff;
      wr_data = cmd.clear_en ? '0 : new_sums;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         sum_mem[wr_addr] <= wr_data;
      end
      if (accept) begin
         rd_data_ff <= sum_mem[ADDR_W'(tcc)];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_addr_ff <= '0;
         fw_valid_ff   <= 1'b0;
      end else begin
         if (cmd.clear_en) begin
            clear_addr_ff <= clear_addr_ff + 1'b1;
            fw_valid_ff   <= 1'b0;
         end else if (mem_we) begin
            fw_valid_ff <= 1'b1;
         end
      end
      if (mem_we) begin
         fw_addr_ff <= wr_addr;
         fw_data_ff <= wr_data;
      end
   end

   // tile index and bound division after a configuration change
   assign cfg_dividend[0] = row_count_ff;
   assign cfg_dividend[1] = col_count_ff;
   assign cfg_dividend[2] = rows_c;
   assign cfg_dividend[3] = cols_c;

   for (genvar g = 0; g < 4; g++) begin : g_cfg_div
      bmp_divider #(.DIVIDEND_W(CNT_W), .DIVISOR_W(TILE_W)) u_div (
         .clock     (clock),
         .reset     (reset),
         .start     (cmd.cfg_start),
         .dividend  (cfg_dividend[g]),
         .divisor   (tile_c),
         .done      (cfg_done[g]),
         .quotient  (cfg_q[g]),
         .remainder (cfg_r[g])
      );
   end

   for (genvar g = 0; g < 3; g++) begin : g_mean_div
      bmp_divider #(.DIVIDEND_W(SUM_W), .DIVISOR_W(AREA_W)) u_div (
         .clock     (clock),
         .reset     (reset),
         .start     (cmd.mean_start),
         .dividend  (new_sums[(2-g)*SUM_W +: SUM_W]),
         .divisor   (area),
         .done      (mean_done[g]),
         .quotient  (mean_q[g]),
         .remainder (mean_r[g])
      );
      assign mean_sat[g] = (mean_q[g] > CH_MAX) ? CH_MAX[CH_W-1:0] : mean_q[g][CH_W-1:0];
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.rsp_load) begin
         rsp_data_ff.origin_row <= s1_org_row_ff;
         rsp_data_ff.origin_col <= s1_org_col_ff;
         rsp_data_ff.red_mean   <= mean_sat[0];
         rsp_data_ff.green_mean <= mean_sat[1];
         rsp_data_ff.blue_mean  <= mean_sat[2];
         rsp_data_ff.frame_done <= s1_done_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      st.clear_last = (clear_addr_ff == CLEAR_LAST);
      st.cfg_done   = cfg_done[0];
      st.mean_done  = mean_done[0];
      st.s1_valid   = s1_valid_ff;
      st.s1_last    = s1_valid_ff && s1_in_tile_ff && s1_last_ff;
      st.rsp_free   = !rsp_valid_ff || !rsp_stall;
   end

   logic unused_bits;
   assign unused_bits = ^{cfg_done[3:1], mean_done[2:1], cfg_r[2], cfg_r[3],
                          mean_r[0], mean_r[1], mean_r[2]};

endmodule

// ===== hdl/bmp_controller.sv =====
// Controller: sequences the clearing pass, tile realignment, mean division
// and result hand-off. Depends on bmp_pkg and the assertion macro header.
`include "block_mean_pixelate_assert.svh"

module bmp_controller (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                csr_valid,
   input  bmp_pkg::status_type st,
   output bmp_pkg::cmd_type    cmd
);
   localparam logic [2:0] ST_CLEAR     = 3'd0;
   localparam logic [2:0] ST_CFG_GO    = 3'd1;
   localparam logic [2:0] ST_CFG_WAIT  = 3'd2;
   localparam logic [2:0] ST_IDLE      = 3'd3;
   localparam logic [2:0] ST_MEAN_WAIT = 3'd4;
   localparam logic [2:0] ST_HOLD      = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       csr_we;

   always_comb begin
      cmd.clear_en   = (state_ff == ST_CLEAR);
      cmd.cfg_start  = (state_ff == ST_CFG_GO);
      cmd.cfg_load   = (state_ff == ST_CFG_WAIT) && st.cfg_done;
      cmd.mean_start = (state_ff == ST_IDLE) && st.s1_last;
      cmd.rsp_load   = ((state_ff == ST_MEAN_WAIT) && st.mean_done && st.rsp_free) ||
                       ((state_ff == ST_HOLD) && st.rsp_free);
      cmd.pix_ready  = (state_ff == ST_IDLE) && !st.s1_last;
      cmd.csr_ready  = (state_ff == ST_CLEAR) ||
                       ((state_ff == ST_IDLE) && !st.s1_valid && !req_valid);
      csr_we         = csr_valid && cmd.csr_ready;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:     if (st.clear_last) state_in = ST_CFG_GO;
         ST_CFG_GO:    state_in = ST_CFG_WAIT;
         ST_CFG_WAIT:  if (st.cfg_done) state_in = ST_IDLE;
         ST_IDLE: begin
            if (csr_we) begin
               state_in = ST_CFG_GO;
            end else if (st.s1_last) begin
               state_in = ST_MEAN_WAIT;
            end
         end
         ST_MEAN_WAIT: if (st.mean_done) state_in = st.rsp_free ? ST_IDLE : ST_HOLD;
         ST_HOLD:      if (st.rsp_free) state_in = ST_IDLE;
         default:      state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   `BMP_ASSERT_NOW(a_cfg_done_waiting, st.cfg_done, state_ff == ST_CFG_WAIT, "realign done out of turn")
   `BMP_ASSERT_NOW(a_mean_done_waiting, st.mean_done, state_ff == ST_MEAN_WAIT, "mean done out of turn")
   `BMP_ASSERT_NEXT(a_no_pixel_behind_tile, st.s1_last, !st.s1_valid, "pixel taken behind a tile end")

endmodule

// ===== hdl/block_mean_pixelate.sv =====
// Top level of the block mean pixelate design: mosaic tile averaging.
// Depends on bmp_pkg, bmp_controller, bmp_datapath and bmp_divider.
//
//  channel   direction  handshake           beat
//  req_*     in         valid / stall       one RGB pixel, raster order
//  rsp_*     out        valid / stall       one tile origin and its three means
//  csr_*     in         valid / ready       register index and write data
//
// Pixels stream back to back until one closes a whole tile. That pixel
// holds the input while three iterative dividers form the three means and
// until the result register is free to take them. After a register write
// the input holds while the tile counters are realigned. After reset a
// clearing pass writes zero to every entry of the tile-column sum memory;
// register writes are taken during it. A stalled result holds in the output
// register; pixels keep flowing until the next tile end needs it.
module block_mean_pixelate #(
   parameter int MAX_COLUMNS  = bmp_pkg::DEF_MAX_COLUMNS,
   parameter int MAX_ROWS     = bmp_pkg::DEF_MAX_ROWS,
   parameter int MAX_TILE     = bmp_pkg::DEF_MAX_TILE,
   parameter int CHANNEL_BITS = bmp_pkg::DEF_CHANNEL_BITS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  bmp_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output bmp_pkg::rsp_type                rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [bmp_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bmp_pkg::CSR_DATA_W-1:0]  csr_data
);
   bmp_pkg::cmd_type    cmd;
   bmp_pkg::status_type st;

   // sequencing only; all arithmetic and storage sit in the datapath
   bmp_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .csr_valid (csr_valid),
      .st        (st),
      .cmd       (cmd)
   );

   bmp_datapath #(
      .MAX_COLUMNS  (MAX_COLUMNS),
      .MAX_ROWS     (MAX_ROWS),
      .MAX_TILE     (MAX_TILE),
      .CHANNEL_BITS (CHANNEL_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .st        (st),
      .req_valid (req_valid),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // stall the pixel stream whenever the controller is not streaming
   assign req_stall = !cmd.pix_ready;
   assign csr_ready = cmd.csr_ready;

endmodule
